// ===== src/connector_status_state_machine_defines.svh =====
// Assertion macros for the connector status state machine.
// Used by csm_status_mem and csm_engine; expects clk and arst_n in scope.
`ifndef CONNECTOR_STATUS_STATE_MACHINE_DEFINES_SVH
`define CONNECTOR_STATUS_STATE_MACHINE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CSM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csm check failed");

// Antecedent implies consequent in the next cycle.
`define CSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csm check failed");

`endif

// ===== src/csm_pkg.sv =====
// Shared types, codes and the status transition table of the connector status block.
// No dependencies.
package csm_pkg;

	localparam int MAX_CONN = 8;
	localparam int DEPTH    = MAX_CONN + 1;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_LIM  = (MAX_CONN < 8) ? MAX_CONN : 8;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_EVENT = 1'b1;

	localparam logic CFG_NUM_CONN = 1'b0;
	localparam logic CFG_OP_MASK  = 1'b1;

	localparam logic [3:0] ST_AVAILABLE   = 4'd0;
	localparam logic [3:0] ST_PREPARING   = 4'd1;
	localparam logic [3:0] ST_CHARGING    = 4'd2;
	localparam logic [3:0] ST_SUSP_EV     = 4'd3;
	localparam logic [3:0] ST_SUSP_EVSE   = 4'd4;
	localparam logic [3:0] ST_FINISHING   = 4'd5;
	localparam logic [3:0] ST_RESERVED    = 4'd6;
	localparam logic [3:0] ST_UNAVAILABLE = 4'd7;
	localparam logic [3:0] ST_FAULTED     = 4'd8;
	localparam logic [3:0] ST_NOGO        = 4'd15;

	localparam logic [4:0] EV_USAGE      = 5'd0;
	localparam logic [4:0] EV_START      = 5'd1;
	localparam logic [4:0] EV_PAUSE_EV   = 5'd2;
	localparam logic [4:0] EV_PAUSE_EVSE = 5'd3;
	localparam logic [4:0] EV_RESERVE    = 5'd4;
	localparam logic [4:0] EV_UNAVAIL    = 5'd5;
	localparam logic [4:0] EV_FAULT      = 5'd6;
	localparam logic [4:0] EV_AVAIL      = 5'd7;
	localparam logic [4:0] EV_STOPPED    = 5'd8;
	localparam logic [4:0] EV_RET_FIRST  = 5'd9;
	localparam logic [4:0] EV_RET_LAST   = 5'd16;

	typedef struct packed {
		logic       cmd;
		logic [3:0] connector;
		logic [4:0] event_code;
	} item_t;

	typedef struct packed {
		logic [3:0] conn_id;
		logic [3:0] status;
		logic       changed;
		logic       last;
	} result_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [3:0]       wr_data;
	} mem_req_t;

	// Clamp the configured count to the table depth and the mask width.
	function automatic logic [3:0] eff_count(input logic [3:0] num);
		logic [3:0] n;
		n = (num > 4'(CNT_LIM)) ? 4'(CNT_LIM) : num;
		return n;
	endfunction

	// Next status for an event, ST_NOGO where the transition is not allowed.
	function automatic logic [3:0] next_status(input logic [3:0] cur, input logic [4:0] ev);
		logic [3:0] nxt;
		nxt = ST_NOGO;
		case (cur)
			ST_AVAILABLE: begin
				case (ev)
					EV_USAGE:      nxt = ST_PREPARING;
					EV_START:      nxt = ST_CHARGING;
					EV_PAUSE_EV:   nxt = ST_SUSP_EV;
					EV_PAUSE_EVSE: nxt = ST_SUSP_EVSE;
					EV_RESERVE:    nxt = ST_RESERVED;
					EV_UNAVAIL:    nxt = ST_UNAVAILABLE;
					EV_FAULT:      nxt = ST_FAULTED;
					default:       nxt = ST_NOGO;
				endcase
			end
			ST_PREPARING: begin
				case (ev)
					EV_START:      nxt = ST_CHARGING;
					EV_PAUSE_EV:   nxt = ST_SUSP_EV;
					EV_PAUSE_EVSE: nxt = ST_SUSP_EVSE;
					EV_FAULT:      nxt = ST_FAULTED;
					EV_AVAIL:      nxt = ST_AVAILABLE;
					EV_STOPPED:    nxt = ST_FINISHING;
					default:       nxt = ST_NOGO;
				endcase
			end
			ST_CHARGING: begin
				case (ev)
					EV_PAUSE_EV:   nxt = ST_SUSP_EV;
					EV_PAUSE_EVSE: nxt = ST_SUSP_EVSE;
					EV_UNAVAIL:    nxt = ST_UNAVAILABLE;
					EV_FAULT:      nxt = ST_FAULTED;
					EV_AVAIL:      nxt = ST_AVAILABLE;
					EV_STOPPED:    nxt = ST_FINISHING;
					default:       nxt = ST_NOGO;
				endcase
			end
			ST_SUSP_EV: begin
				case (ev)
					EV_START:      nxt = ST_CHARGING;
					EV_PAUSE_EVSE: nxt = ST_SUSP_EVSE;
					EV_UNAVAIL:    nxt = ST_UNAVAILABLE;
					EV_FAULT:      nxt = ST_FAULTED;
					EV_AVAIL:      nxt = ST_AVAILABLE;
					EV_STOPPED:    nxt = ST_FINISHING;
					default:       nxt = ST_NOGO;
				endcase
			end
			ST_SUSP_EVSE: begin
				case (ev)
					EV_START:      nxt = ST_CHARGING;
					EV_PAUSE_EV:   nxt = ST_SUSP_EV;
					EV_UNAVAIL:    nxt = ST_UNAVAILABLE;
					EV_FAULT:      nxt = ST_FAULTED;
					EV_AVAIL:      nxt = ST_AVAILABLE;
					EV_STOPPED:    nxt = ST_FINISHING;
					default:       nxt = ST_NOGO;
				endcase
			end
			ST_FINISHING, ST_RESERVED: begin
				case (ev)
					EV_USAGE:   nxt = ST_PREPARING;
					EV_UNAVAIL: nxt = ST_UNAVAILABLE;
					EV_FAULT:   nxt = ST_FAULTED;
					EV_AVAIL:   nxt = ST_AVAILABLE;
					default:    nxt = ST_NOGO;
				endcase
			end
			ST_UNAVAILABLE: begin
				case (ev)
					EV_USAGE:      nxt = ST_PREPARING;
					EV_START:      nxt = ST_CHARGING;
					EV_PAUSE_EV:   nxt = ST_SUSP_EV;
					EV_PAUSE_EVSE: nxt = ST_SUSP_EVSE;
					EV_FAULT:      nxt = ST_FAULTED;
					EV_AVAIL:      nxt = ST_AVAILABLE;
					default:       nxt = ST_NOGO;
				endcase
			end
			ST_FAULTED: begin
				// Return events restore the status given by their offset.
				if (ev >= EV_RET_FIRST && ev <= EV_RET_LAST) begin
					nxt = 4'(ev - EV_RET_FIRST);
				end
			end
			default: nxt = ST_NOGO;
		endcase
		return nxt;
	endfunction

endpackage

// ===== src/csm_status_mem.sv =====
// Status memory: one 4-bit entry per connector, registered read port.
// Depends on csm_pkg and the assertion macro header.
`include "connector_status_state_machine_defines.svh"

module csm_status_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  csm_pkg::mem_req_t req,
	output logic [3:0]        rdata
);
	import csm_pkg::*;

	logic [3:0]       mem [DEPTH];
	logic [3:0]       rdata_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr];
		end
	end

	// Entries never written read as Unavailable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rdata_q : ST_UNAVAILABLE;

	`CSM_ASSERT_SAME(a_no_rw_collision, req.wr_en && req.rd_en, req.wr_addr != req.rd_addr)
	`CSM_ASSERT_NEXT(a_write_marks_valid, req.wr_en, vld_q[$past(req.wr_addr)])

endmodule

// ===== src/csm_engine.sv =====
// Sequencer: accepts transactions, walks the start sweep and does read-modify-write
// of connector status, and holds the result register. Depends on csm_pkg and macros.
`include "connector_status_state_machine_defines.svh"

module csm_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  csm_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output csm_pkg::result_t  result,
	input  logic [3:0]        num_connectors,
	input  logic [8:0]        operative_mask,
	output csm_pkg::mem_req_t mem_req,
	input  logic [3:0]        mem_rdata
);
	import csm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_START = 4'b0010,
		S_READ  = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       started_q, started_d;
	logic [3:0] conn_q;
	logic [4:0] ev_q;
	result_t    result_q, res_d;
	logic       result_valid_q;
	logic       load;
	logic       slot_free;
	logic       accept;
	logic [3:0] n;
	logic [3:0] nxt;
	logic [3:0] start_st;

	assign n          = eff_count(num_connectors);
	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign slot_free  = !result_valid_q || !result_stall;
	assign nxt        = next_status(mem_rdata, ev_q);
	assign start_st   = operative_mask[cnt_q] ? ST_AVAILABLE : ST_UNAVAILABLE;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		started_d = started_q;
		load      = 1'b0;
		res_d     = '0;
		mem_req   = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.cmd == CMD_START) begin
						cnt_d   = '0;
						state_d = S_START;
					end else if (started_q) begin
						if (item.connector != '0 && item.connector <= n) begin
							mem_req.rd_en   = 1'b1;
							mem_req.rd_addr = IDX_W'(item.connector);
							state_d         = S_READ;
						end else begin
							state_d = S_RESP;
						end
					end
				end
			end
			S_START: begin
				if (slot_free) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = IDX_W'(cnt_q);
					mem_req.wr_data = start_st;
					load            = 1'b1;
					res_d.conn_id   = cnt_q;
					res_d.status    = start_st;
					res_d.changed   = 1'b1;
					res_d.last      = (cnt_q == n);
					if (cnt_q == n) begin
						started_d = 1'b1;
						state_d   = S_IDLE;
					end else begin
						cnt_d = cnt_q + 4'd1;
					end
				end
			end
			S_READ: begin
				if (slot_free) begin
					load          = 1'b1;
					res_d.conn_id = conn_q;
					res_d.last    = 1'b1;
					if (nxt != ST_NOGO) begin
						mem_req.wr_en   = 1'b1;
						mem_req.wr_addr = IDX_W'(conn_q);
						mem_req.wr_data = nxt;
						res_d.status    = nxt;
						res_d.changed   = 1'b1;
					end else begin
						res_d.status  = mem_rdata;
						res_d.changed = 1'b0;
					end
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (slot_free) begin
					load          = 1'b1;
					res_d.conn_id = conn_q;
					res_d.status  = (conn_q == '0) ? ST_AVAILABLE : ST_UNAVAILABLE;
					res_d.changed = 1'b0;
					res_d.last    = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			started_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			started_q <= started_d;
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			conn_q <= item.connector;
			ev_q   <= item.event_code;
		end
		if (load) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`CSM_ASSERT_SAME(a_no_write_when_idle, state_q == S_IDLE, !mem_req.wr_en)
	`CSM_ASSERT_NEXT(a_read_then_modify, mem_req.rd_en, state_q == S_READ)
	`CSM_ASSERT_NEXT(a_sweep_end, state_q == S_START && slot_free && cnt_q == n, state_q == S_IDLE && started_q)
	`CSM_ASSERT_SAME(a_load_needs_slot, load, slot_free)

endmodule

// ===== src/connector_status_state_machine.sv =====
// Connector status state machine top: configuration registers, sequencer, status memory.
// Depends on csm_pkg, csm_engine and csm_status_mem.
// Results: an event's result is loaded into the result register from S_READ or S_RESP once the
// result slot is free; a start loads one result per connector 0..n in order, each once the slot is free.
// A new transaction is taken only while idle, after the previous one has finished; result stalls hold it.
// Reset: idle, count 1, mask all ones, connectors Unavailable; events dropped until a start.

module connector_status_state_machine (
	input  logic             clk,
	input  logic             arst_n,
	// Input transactions
	input  logic             item_valid,
	output logic             item_stall,
	input  csm_pkg::item_t   item,
	// Result transactions
	output logic             result_valid,
	input  logic             result_stall,
	output csm_pkg::result_t result,
	// Configuration writes
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [8:0]       cfg_data
);
	import csm_pkg::*;

	logic [3:0] num_connectors_q;
	logic [8:0] operative_mask_q;
	mem_req_t   mem_req;
	logic [3:0] mem_rdata;

	// Configuration must be written only while idle; the block does not enforce this, so always take it.
	assign cfg_ready = 1'b1;

	// Hold the registers; a write lands on the edge where valid and ready meet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_connectors_q <= 4'd1;
			operative_mask_q <= 9'h1FF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUM_CONN: num_connectors_q <= cfg_data[3:0];
				CFG_OP_MASK:  operative_mask_q <= cfg_data;
				default:      num_connectors_q <= num_connectors_q;
			endcase
		end
	end

	// Sequencer: accept, sweep on start, read-modify-write on an event,
	// and drive the result register.
	csm_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.num_connectors (num_connectors_q),
		.operative_mask (operative_mask_q),
		.mem_req        (mem_req),
		.mem_rdata      (mem_rdata)
	);

	// Per-connector status storage with a registered read.
	csm_status_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

endmodule
